// ----- design/pcanon_pkg.sv -----
package pcanon_pkg;

  // Default size of the directory and path stores, in bytes
  localparam int BUF_BYTES_DEF = 256;

  // Result store
  localparam int RES_DEPTH = 256;
  localparam int RES_AW    = 8;

  // Capacity register
  localparam int              CAP_W   = 9;
  localparam logic [CAP_W-1:0] CAP_RST = 9'd256;

  // Action codes
  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_LDDIR  = 3'd1;
  localparam logic [2:0] ACT_LDPATH = 3'd2;
  localparam logic [2:0] ACT_FINISH = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] ch;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] out_len;
    logic       accepted;
  } out_item_t;

  // Start request to the finish engine
  typedef struct packed {
    logic             start;
    logic [CAP_W-1:0] cap;
  } eng_cmd_t;

  // Completion status from the finish engine
  typedef struct packed {
    logic       done;
    logic [7:0] olen;
  } eng_sts_t;

endpackage

// ----- design/path_canonicalizer.sv -----
// Path canonicalizer. Directory and path bytes are loaded one per transfer
// into a shared input RAM (directory in the lower half, path in the upper);
// a finish transfer builds the absolute, normalized path into a 256-byte
// result RAM, which read transfers then return by index. Every input
// transfer yields exactly one output transfer carrying the byte read (zero
// unless it is a read), the current result length and an accepted flag
// (low on a load into a full store, on finish with capacity zero and on an
// undefined action). Clear, loads and undefined actions leave the block idle
// and may follow each other every cycle while the output is not stalled; a
// read waits for the registered RAM read. Finish is a sequencer around the
// two RAMs, one byte at a time: it scans the path and then the directory up
// to their terminators, streams the joined string through the normalizer,
// and on each ".." walks the result RAM back to the previous slash. No
// clearing pass after reset: the RAMs hold nothing that is read before it is
// written. The capacity register may only be written while idle.
module path_canonicalizer #(
  parameter int BUF_BYTES = pcanon_pkg::BUF_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pcanon_pkg::in_item_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pcanon_pkg::out_item_t         out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pcanon_pkg::CAP_W-1:0]  cfg_wdata_i
);
  import pcanon_pkg::*;

  localparam int LW = $clog2(BUF_BYTES + 1);
  localparam int AW = $clog2(BUF_BYTES);
  localparam int IN_DEPTH = 2 ** (AW + 1);
  localparam logic [LW-1:0] BUF_L = LW'(BUF_BYTES);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_FIN  = 2'd1;  // finish engine running
  localparam logic [1:0] T_RDW  = 2'd2;  // waiting on result RAM read

  logic [1:0]       state_q, state_d;
  logic [LW-1:0]    dir_len_q, dir_len_d;
  logic [LW-1:0]    path_len_q, path_len_d;
  logic [7:0]       res_len_q, res_len_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             hit_q, hit_d;

  logic             in_acc;
  logic [CAP_W-1:0] cap_eff;

  // input RAM
  logic          in_we;
  logic [AW:0]   in_waddr, in_raddr;
  logic [7:0]    in_rdata;

  // result RAM
  logic              res_we;
  logic [RES_AW-1:0] res_waddr, res_raddr, eng_res_raddr;
  logic [7:0]        res_wdata, res_rdata;

  eng_cmd_t eng_cmd;
  eng_sts_t eng_sts;

  // a new item is taken only when idle and the output register frees up
  assign in_stall_o  = (state_q != T_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cap_eff   = (cap_q > CAP_W'(RES_DEPTH)) ? CAP_W'(RES_DEPTH) : cap_q;
  assign res_raddr = (state_q == T_FIN) ? eng_res_raddr : in_data_i.read_index;

  always_comb begin
    state_d     = state_q;
    dir_len_d   = dir_len_q;
    path_len_d  = path_len_q;
    res_len_d   = res_len_q;
    cap_d       = cfg_we_i ? cfg_wdata_i : cap_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    hit_d       = hit_q;
    in_we       = 1'b0;
    in_waddr    = {1'b0, dir_len_q[AW-1:0]};
    eng_cmd     = '0;
    eng_cmd.cap = cap_eff;

    unique case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          out_d.out_byte = '0;
          out_d.out_len  = res_len_q;
          out_d.accepted = 1'b1;
          unique case (in_data_i.action)
            ACT_CLEAR: begin
              dir_len_d     = '0;
              path_len_d    = '0;
              res_len_d     = '0;
              out_d.out_len = '0;
              out_valid_d   = 1'b1;
            end
            ACT_LDDIR: begin
              if (dir_len_q < BUF_L) begin
                in_we     = 1'b1;
                in_waddr  = {1'b0, dir_len_q[AW-1:0]};
                dir_len_d = dir_len_q + LW'(1);
              end else begin
                out_d.accepted = 1'b0;
              end
              out_valid_d = 1'b1;
            end
            ACT_LDPATH: begin
              if (path_len_q < BUF_L) begin
                in_we      = 1'b1;
                in_waddr   = {1'b1, path_len_q[AW-1:0]};
                path_len_d = path_len_q + LW'(1);
              end else begin
                out_d.accepted = 1'b0;
              end
              out_valid_d = 1'b1;
            end
            ACT_FINISH: begin
              if (cap_eff == '0) begin
                out_d.accepted = 1'b0;
                out_valid_d    = 1'b1;
              end else begin
                eng_cmd.start = 1'b1;
                state_d       = T_FIN;
              end
            end
            ACT_READ: begin
              hit_d   = in_data_i.read_index < res_len_q;
              state_d = T_RDW;
            end
            default: begin
              out_d.accepted = 1'b0;
              out_valid_d    = 1'b1;
            end
          endcase
        end
      end

      T_FIN: begin
        if (eng_sts.done) begin
          res_len_d      = eng_sts.olen;
          out_d.out_byte = '0;
          out_d.out_len  = eng_sts.olen;
          out_d.accepted = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = T_IDLE;
        end
      end

      T_RDW: begin
        out_d.out_byte = hit_q ? res_rdata : 8'd0;
        out_d.out_len  = res_len_q;
        out_d.accepted = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = T_IDLE;
      end

      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      dir_len_q   <= '0;
      path_len_q  <= '0;
      res_len_q   <= '0;
      cap_q       <= CAP_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_len_q   <= dir_len_d;
      path_len_q  <= path_len_d;
      res_len_q   <= res_len_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    hit_q <= hit_d;
  end

  pcanon_ram #(
    .WIDTH (8),
    .DEPTH (IN_DEPTH)
  ) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (in_waddr),
    .wdata_i (in_data_i.ch),
    .raddr_i (in_raddr),
    .rdata_o (in_rdata)
  );

  pcanon_ram #(
    .WIDTH (8),
    .DEPTH (RES_DEPTH)
  ) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (res_raddr),
    .rdata_o (res_rdata)
  );

  pcanon_engine #(
    .BUF_BYTES (BUF_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (eng_cmd),
    .dir_len_i   (dir_len_q),
    .path_len_i  (path_len_q),
    .sts_o       (eng_sts),
    .in_raddr_o  (in_raddr),
    .in_rdata_i  (in_rdata),
    .res_we_o    (res_we),
    .res_waddr_o (res_waddr),
    .res_wdata_o (res_wdata),
    .res_raddr_o (eng_res_raddr),
    .res_rdata_i (res_rdata)
  );

endmodule

// ----- design/pcanon_ram.sv -----
module pcanon_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pcanon_engine.sv -----
module pcanon_engine #(
  parameter int BUF_BYTES = pcanon_pkg::BUF_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcanon_pkg::eng_cmd_t             cmd_i,
  input  logic [$clog2(BUF_BYTES+1)-1:0]   dir_len_i,
  input  logic [$clog2(BUF_BYTES+1)-1:0]   path_len_i,
  output pcanon_pkg::eng_sts_t             sts_o,
  output logic [$clog2(BUF_BYTES):0]       in_raddr_o,
  input  logic [7:0]                       in_rdata_i,
  output logic                             res_we_o,
  output logic [pcanon_pkg::RES_AW-1:0]    res_waddr_o,
  output logic [7:0]                       res_wdata_o,
  output logic [pcanon_pkg::RES_AW-1:0]    res_raddr_o,
  input  logic [7:0]                       res_rdata_i
);
  import pcanon_pkg::*;

  localparam int LW  = $clog2(BUF_BYTES + 1);
  localparam int AW  = $clog2(BUF_BYTES);
  localparam int LW1 = LW + 1;
  localparam int SW  = ((LW > CAP_W) ? LW : CAP_W) + 1;

  localparam logic [3:0] E_IDLE  = 4'd0;
  localparam logic [3:0] E_SP_RD = 4'd1;
  localparam logic [3:0] E_SP_CK = 4'd2;
  localparam logic [3:0] E_SD_RD = 4'd3;
  localparam logic [3:0] E_SD_CK = 4'd4;
  localparam logic [3:0] E_CALC  = 4'd5;
  localparam logic [3:0] E_ST_RD = 4'd6;
  localparam logic [3:0] E_ST_PR = 4'd7;
  localparam logic [3:0] E_BK_RD = 4'd8;
  localparam logic [3:0] E_BK_CK = 4'd9;
  localparam logic [3:0] E_DONE  = 4'd10;

  localparam logic [1:0] PH_DIR  = 2'd0;
  localparam logic [1:0] PH_SEP  = 2'd1;
  localparam logic [1:0] PH_PATH = 2'd2;
  localparam logic [1:0] PH_END  = 2'd3;

  logic [3:0]       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [LW-1:0]    idx_q, idx_d;
  logic [LW-1:0]    plen_q, plen_d;
  logic [LW-1:0]    dlen_q, dlen_d;
  logic [LW-1:0]    clen_q, clen_d;
  logic [7:0]       last_q, last_d;
  logic [7:0]       olen_q, olen_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic             p0slash_q, p0slash_d;
  logic             dir_go_q, dir_go_d;
  logic             path_go_q, path_go_d;
  logic             from_ram_q, from_ram_d;
  logic             in_comp_q, in_comp_d;
  logic             c0dot_q, c0dot_d;
  logic             c1dot_q, c1dot_d;

  // Prefix decision, evaluated in E_CALC
  logic          use_dir, dir_go, path_go;
  logic [LW-1:0] dlen_eff, pos;

  // Normalizer datapath
  logic [7:0]    cur_byte;
  logic          sep;
  logic [SW-1:0] base, waddr_w, fit_sum;
  logic          dot1, dot2;

  always_comb begin
    use_dir  = (plen_q == '0) || !p0slash_q;
    dlen_eff = (dlen_q == '0) ? LW'(1) : dlen_q;
    dir_go   = use_dir && (dlen_eff < LW'(BUF_BYTES - 2));
    if (!dir_go) begin
      pos = '0;
    end else if (dlen_q == '0) begin
      pos = LW'(1);
    end else begin
      pos = dlen_q + LW'(last_q != CH_SLASH);
    end
    path_go = (LW1'(pos) + LW1'(plen_q) + LW1'(1)) < LW1'(BUF_BYTES);
  end

  always_comb begin
    cur_byte = from_ram_q ? in_rdata_i : CH_SLASH;
    sep      = olen_q > 8'd1;
    base     = SW'(olen_q) + SW'(sep);
    waddr_w  = base + SW'(clen_q);
    fit_sum  = SW'(olen_q) + SW'(clen_q) + SW'(2);
    dot1     = (clen_q == LW'(1)) && c0dot_q;
    dot2     = (clen_q == LW'(2)) && c0dot_q && c1dot_q;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    plen_d      = plen_q;
    dlen_d      = dlen_q;
    clen_d      = clen_q;
    last_d      = last_q;
    olen_d      = olen_q;
    cap_d       = cap_q;
    p0slash_d   = p0slash_q;
    dir_go_d    = dir_go_q;
    path_go_d   = path_go_q;
    from_ram_d  = from_ram_q;
    in_comp_d   = in_comp_q;
    c0dot_d     = c0dot_q;
    c1dot_d     = c1dot_q;
    in_raddr_o  = '0;
    res_we_o    = 1'b0;
    res_waddr_o = '0;
    res_wdata_o = CH_SLASH;
    res_raddr_o = '0;
    sts_o       = '0;

    unique case (state_q)
      E_IDLE: begin
        if (cmd_i.start) begin
          idx_d     = '0;
          p0slash_d = 1'b0;
          last_d    = CH_NUL;
          cap_d     = cmd_i.cap;
          state_d   = E_SP_RD;
        end
      end

      // path length up to the first zero byte
      E_SP_RD: begin
        if (idx_q == path_len_i) begin
          plen_d  = idx_q;
          idx_d   = '0;
          state_d = E_SD_RD;
        end else begin
          in_raddr_o = {1'b1, idx_q[AW-1:0]};
          state_d    = E_SP_CK;
        end
      end

      E_SP_CK: begin
        if (in_rdata_i == CH_NUL) begin
          plen_d  = idx_q;
          idx_d   = '0;
          state_d = E_SD_RD;
        end else begin
          if (idx_q == '0) begin
            p0slash_d = (in_rdata_i == CH_SLASH);
          end
          idx_d   = idx_q + LW'(1);
          state_d = E_SP_RD;
        end
      end

      // directory length, remembering its last byte
      E_SD_RD: begin
        if (idx_q == dir_len_i) begin
          dlen_d  = idx_q;
          state_d = E_CALC;
        end else begin
          in_raddr_o = {1'b0, idx_q[AW-1:0]};
          state_d    = E_SD_CK;
        end
      end

      E_SD_CK: begin
        if (in_rdata_i == CH_NUL) begin
          dlen_d  = idx_q;
          state_d = E_CALC;
        end else begin
          last_d  = in_rdata_i;
          idx_d   = idx_q + LW'(1);
          state_d = E_SD_RD;
        end
      end

      E_CALC: begin
        dir_go_d    = dir_go;
        path_go_d   = path_go;
        res_we_o    = 1'b1;
        res_waddr_o = '0;
        res_wdata_o = CH_SLASH;
        olen_d      = 8'd1;
        in_comp_d   = 1'b0;
        clen_d      = '0;
        c0dot_d     = 1'b0;
        c1dot_d     = 1'b0;
        phase_d     = PH_DIR;
        idx_d       = '0;
        state_d     = E_ST_RD;
      end

      // stream: directory, separator, path, final separator
      E_ST_RD: begin
        unique case (phase_q)
          PH_DIR: begin
            if (dir_go_q && (idx_q < dlen_q)) begin
              in_raddr_o = {1'b0, idx_q[AW-1:0]};
              from_ram_d = 1'b1;
              state_d    = E_ST_PR;
            end else begin
              phase_d = PH_SEP;
            end
          end
          PH_SEP: begin
            from_ram_d = 1'b0;
            idx_d      = '0;
            phase_d    = PH_PATH;
            state_d    = E_ST_PR;
          end
          PH_PATH: begin
            if (path_go_q && (idx_q < plen_q)) begin
              in_raddr_o = {1'b1, idx_q[AW-1:0]};
              from_ram_d = 1'b1;
            end else begin
              from_ram_d = 1'b0;
              phase_d    = PH_END;
            end
            state_d = E_ST_PR;
          end
          PH_END: begin
            state_d = E_DONE;
          end
          default: begin
            state_d = E_DONE;
          end
        endcase
      end

      E_ST_PR: begin
        state_d = E_ST_RD;
        if (from_ram_q) begin
          idx_d = idx_q + LW'(1);
        end
        if (cur_byte != CH_SLASH) begin
          // component bytes go in speculatively past the kept length
          if (clen_q == '0) begin
            c0dot_d = (cur_byte == CH_DOT);
          end
          if (clen_q == LW'(1)) begin
            c1dot_d = (cur_byte == CH_DOT);
          end
          if (waddr_w < SW'(RES_DEPTH)) begin
            res_we_o    = 1'b1;
            res_waddr_o = waddr_w[RES_AW-1:0];
            res_wdata_o = cur_byte;
          end
          clen_d    = clen_q + LW'(1);
          in_comp_d = 1'b1;
        end else if (in_comp_q) begin
          in_comp_d = 1'b0;
          clen_d    = '0;
          c0dot_d   = 1'b0;
          c1dot_d   = 1'b0;
          if (dot1) begin
            // "." : nothing kept
          end else if (dot2) begin
            if (sep) begin
              olen_d  = olen_q - 8'd1;
              state_d = E_BK_RD;
            end
          end else if (fit_sum >= SW'(cap_q)) begin
            state_d = E_DONE;
          end else begin
            if (sep) begin
              res_we_o    = 1'b1;
              res_waddr_o = olen_q;
              res_wdata_o = CH_SLASH;
            end
            olen_d = waddr_w[7:0];
          end
        end
      end

      // "..": step back to the previous slash, not below the root
      E_BK_RD: begin
        if (olen_q <= 8'd1) begin
          state_d = E_ST_RD;
        end else begin
          res_raddr_o = olen_q - 8'd1;
          state_d     = E_BK_CK;
        end
      end

      E_BK_CK: begin
        if (res_rdata_i == CH_SLASH) begin
          state_d = E_ST_RD;
        end else begin
          olen_d  = olen_q - 8'd1;
          state_d = E_BK_RD;
        end
      end

      E_DONE: begin
        sts_o.done = 1'b1;
        sts_o.olen = olen_q;
        state_d    = E_IDLE;
      end

      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q    <= phase_d;
    idx_q      <= idx_d;
    plen_q     <= plen_d;
    dlen_q     <= dlen_d;
    clen_q     <= clen_d;
    last_q     <= last_d;
    olen_q     <= olen_d;
    cap_q      <= cap_d;
    p0slash_q  <= p0slash_d;
    dir_go_q   <= dir_go_d;
    path_go_q  <= path_go_d;
    from_ram_q <= from_ram_d;
    in_comp_q  <= in_comp_d;
    c0dot_q    <= c0dot_d;
    c1dot_q    <= c1dot_d;
  end

endmodule

// ----- dv/tb_path_canonicalizer.sv -----
module tb_path_canonicalizer;
  import pcanon_pkg::*;

  // Actions the block does not define; each must come back with accepted low
  localparam logic [2:0] ACT_RSVD_A = 3'd5;
  localparam logic [2:0] ACT_RSVD_B = 3'd6;
  localparam logic [2:0] ACT_RSVD_C = 3'd7;

  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off, fills the block
  localparam int PHASE_ITEMS   = 1;       // minimum transfers per capacity setting
  localparam int SETTLE_CYCLES = 64;      // quiet time after the last result
  // Roughly 500 transfers. Worst case per transfer: a mostly stalled receiver,
  // a sender gap and the block's own handling; a few dozen finishes and one
  // long receiver hold. The limit is several times the expected total.
  localparam int CYCLE_LIMIT   = 1000000;

  // Scoreboard: carries its own copy of the loaded strings, the result buffer
  // and the capacity register, and predicts one reply per input transfer.
  class canon_scoreboard;
    logic [7:0] dir_mem [BUF_BYTES_DEF];
    logic [7:0] path_mem[BUF_BYTES_DEF];
    logic [7:0] res_mem [RES_DEPTH];
    int         dir_len;
    int         path_len;
    int         res_len;
    int         capacity;
    int         error_count;
    out_item_t  replies_due[$];

    function new();
      dir_len     = 0;
      path_len    = 0;
      res_len     = 0;
      capacity    = int'(CAP_RST);
      error_count = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = int'(value);
    endfunction

    // Length up to the first NUL, bounded by what was loaded
    function int text_length(bit of_path);
      int n;
      n = 0;
      if (of_path) begin
        while (n < path_len && path_mem[n] != CH_NUL) n++;
      end else begin
        while (n < dir_len && dir_mem[n] != CH_NUL) n++;
      end
      return n;
    endfunction

    // Join directory and path, then normalize into res_mem
    function bit canonicalize();
      logic [7:0] joined [BUF_BYTES_DEF];
      int cap, pos, plen, dlen, olen, i, k, start, clen;
      cap = (capacity > RES_DEPTH) ? RES_DEPTH : capacity;
      if (cap == 0) return 1'b0;
      pos  = 0;
      plen = text_length(1'b1);
      if (plen == 0 || path_mem[0] != CH_SLASH) begin
        dlen = text_length(1'b0);
        if (dlen == 0) begin
          // no directory: root stands in
          joined[0] = CH_SLASH;
          pos = 1;
        end else if (dlen < BUF_BYTES_DEF - 2) begin
          for (k = 0; k < dlen; k++) joined[k] = dir_mem[k];
          pos = dlen;
          if (joined[pos-1] != CH_SLASH) begin
            joined[pos] = CH_SLASH;
            pos++;
          end
        end
      end
      if (pos + plen + 1 < BUF_BYTES_DEF) begin
        for (k = 0; k < plen; k++) joined[pos+k] = path_mem[k];
        pos += plen;
      end

      res_mem[0] = CH_SLASH;
      olen = 1;
      i = 0;
      while (i < pos) begin
        while (i < pos && joined[i] == CH_SLASH) i++;
        if (i >= pos) break;
        start = i;
        while (i < pos && joined[i] != CH_SLASH) i++;
        clen = i - start;
        if (clen == 1 && joined[start] == CH_DOT) continue;
        if (clen == 2 && joined[start] == CH_DOT && joined[start+1] == CH_DOT) begin
          if (olen > 1) begin
            olen--;
            while (olen > 1 && res_mem[olen-1] != CH_SLASH) olen--;
          end
          continue;
        end
        if (olen + clen + 2 >= cap) break;   // component does not fit: scan ends
        if (olen > 1) begin
          res_mem[olen] = CH_SLASH;
          olen++;
        end
        for (k = 0; k < clen; k++) res_mem[olen+k] = joined[start+k];
        olen += clen;
      end
      res_len = olen % 256;
      return 1'b1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t want;
      want          = '0;
      want.accepted = 1'b1;
      case (it.action)
        ACT_CLEAR: begin
          dir_len  = 0;
          path_len = 0;
          res_len  = 0;
        end
        ACT_LDDIR: begin
          if (dir_len < BUF_BYTES_DEF) begin
            dir_mem[dir_len] = it.ch;
            dir_len++;
          end else want.accepted = 1'b0;
        end
        ACT_LDPATH: begin
          if (path_len < BUF_BYTES_DEF) begin
            path_mem[path_len] = it.ch;
            path_len++;
          end else want.accepted = 1'b0;
        end
        ACT_FINISH: want.accepted = canonicalize();
        ACT_READ: begin
          if (int'(it.read_index) < res_len) want.out_byte = res_mem[it.read_index];
        end
        default: want.accepted = 1'b0;
      endcase
      want.out_len = 8'(res_len);
      replies_due.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        report_mismatch("transfer with nothing expected", int'(got), 0);
        return;
      end
      want = replies_due.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
      if (got.out_len !== want.out_len)
        report_mismatch("out_len", int'(got.out_len), int'(want.out_len));
      if (got.accepted !== want.accepted)
        report_mismatch("accepted", int'(got.accepted), int'(want.accepted));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  canon_scoreboard sb = new();

  int  cycle_count = 0;
  int  items_sent  = 0;
  int  burst_left  = 0;
  bit  no_gaps     = 1'b0;   // sender offers back to back while set
  bit  hold_req    = 1'b0;   // asks the receiver for its one long hold-off
  logic [7:0] text_q[$];     // bytes waiting to be loaded

  initial begin
    forever #6 clk = ~clk;
  end

  path_canonicalizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Watchdog: a hung handshake ends the run here
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks every output transfer, stalls in modes that change at
  // random (none, light, half, heavy) and once holds off for a long stretch
  // so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int mode, mode_left, hold_left;
    bit hold_used;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_req && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 7) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_item(logic [2:0] act, logic [7:0] c, logic [7:0] idx);
    in_item_t it;
    it.action     = act;
    it.ch         = c;
    it.read_index = idx;
    return it;
  endfunction

  // One input transfer. Bursts of random length, random gaps between them
  // (a quarter of bursts follow on with no gap). valid stays high between
  // back-to-back items; the caller lowers it before going quiet.
  task automatic send_item(in_item_t it);
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    sb.note_input(it);
  endtask

  task automatic send_op(logic [2:0] act);
    send_item(mk_item(act, 8'($urandom), 8'($urandom)));
  endtask

  task automatic read_at(int idx);
    send_item(mk_item(ACT_READ, 8'($urandom), 8'(idx)));
  endtask

  // Full read-back walks every index and one past the end
  task automatic read_back(bit full);
    int k;
    if (full) begin
      for (k = 0; k <= sb.res_len; k++) read_at(k);
    end else begin
      if (sb.res_len > 0) read_at(sb.res_len - 1);
      read_at(sb.res_len);
    end
    read_at($urandom_range(0, 255));
  endtask

  task automatic load_string(logic [2:0] act, string s);
    int k;
    for (k = 0; k < s.len(); k++) send_item(mk_item(act, s[k], 8'($urandom)));
  endtask

  task automatic load_text(logic [2:0] act);
    int k;
    for (k = 0; k < text_q.size(); k++) send_item(mk_item(act, text_q[k], 8'($urandom)));
    text_q.delete();
  endtask

  // Random path text: names, ".", "..", odd bytes (high half too), the odd
  // NUL, single and repeated slashes, sometimes a trailing slash.
  task automatic gen_text(int n_comp, bit lead_slash, bit nul_ok);
    int k, j, n;
    if (lead_slash) text_q.push_back(CH_SLASH);
    for (k = 0; k < n_comp; k++) begin
      if (k > 0) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n) text_q.push_back(CH_SLASH);
      end
      case ($urandom_range(0, 9))
        0: text_q.push_back(CH_DOT);
        1, 2: begin
          text_q.push_back(CH_DOT);
          text_q.push_back(CH_DOT);
        end
        3: text_q.push_back(8'($urandom_range(1, 255)));
        4: begin
          if (nul_ok && $urandom_range(0, 2) == 0) text_q.push_back(CH_NUL);
          else text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
        end
        default: begin
          n = $urandom_range(1, 7);
          for (j = 0; j < n; j++) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) text_q.push_back(CH_SLASH);
  endtask

  // Typical use: clear, directory, path, finish, read back
  task automatic run_sequence();
    if ($urandom_range(0, 5) != 0) send_op(ACT_CLEAR);
    if ($urandom_range(0, 3) != 0) begin
      gen_text($urandom_range(0, 4), $urandom_range(0, 9) != 0, 1'b1);
      load_text(ACT_LDDIR);
    end
    gen_text($urandom_range(0, 5), $urandom_range(0, 2) == 0, 1'b1);
    load_text(ACT_LDPATH);
    send_op(ACT_FINISH);
    read_back($urandom_range(0, 1) == 0);
    if ($urandom_range(0, 4) == 0) begin
      send_op(ACT_FINISH);   // loads are kept, same result again
      read_at($urandom_range(0, 255));
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 4)) send_item(mk_item(3'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  // Size limits: directory just under the drop threshold (the path may then
  // be too long to join), directory at the threshold, then the directory
  // store filled and overrun. The receiver's long hold-off lands here while
  // the sender runs flat out.
  task automatic run_long_sequence();
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    send_op(ACT_CLEAR);
    while (text_q.size() < BUF_BYTES_DEF - 3) gen_text(4, text_q.size() == 0, 1'b0);
    text_q = text_q[0:BUF_BYTES_DEF-4];
    load_text(ACT_LDDIR);
    send_item(mk_item(ACT_LDPATH, 8'($urandom_range(8'h61, 8'h7A)), 8'($urandom)));
    send_op(ACT_FINISH);
    read_back(1'b0);
    send_item(mk_item(ACT_LDDIR, 8'($urandom_range(8'h61, 8'h7A)), 8'($urandom)));
    send_op(ACT_FINISH);
    read_back(1'b0);
    // two more fill the directory store, the third is refused
    repeat (3) send_item(mk_item(ACT_LDDIR, 8'($urandom_range(8'h61, 8'h7A)), 8'($urandom)));
    send_op(ACT_FINISH);
    read_back(1'b0);
    no_gaps = 1'b0;
  endtask

  // Capacity writes only with nothing in flight: every transfer gets a reply,
  // so an empty scoreboard means the block is idle.
  task automatic set_capacity(logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(value);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int cap_plan[11];
    int p, phase_start;

    cap_plan = '{256, 0, 1, 2, 3, 511, 257, 8, 16, 24, 48};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty result, finish with nothing loaded (root), undefined
    // actions with all-ones fields, then a relative path through "." and ".."
    send_item(mk_item(ACT_READ, 8'hFF, 8'hFF));
    send_item(mk_item(ACT_FINISH, 8'h00, 8'h00));
    send_item(mk_item(ACT_READ, 8'h00, 8'h00));
    send_item(mk_item(ACT_RSVD_A, 8'hFF, 8'hFF));
    send_item(mk_item(ACT_RSVD_B, 8'hFF, 8'hFF));
    send_item(mk_item(ACT_RSVD_C, 8'hFF, 8'hFF));
    send_op(ACT_CLEAR);
    load_string(ACT_LDDIR, "/x");
    load_string(ACT_LDPATH, "../y/./z/..");
    send_op(ACT_FINISH);
    read_at(1);

    // Random part, one phase per capacity setting; the size-limit run goes
    // in with full capacity.
    for (p = 0; p <= 11; p++) begin
      if (p < 11) set_capacity(9'(cap_plan[p]));
      else set_capacity(9'($urandom_range(1, 256)));
      if (p == 0) run_long_sequence();
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) run_noise();
        else run_sequence();
      end
    end

    in_valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.replies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
